// ===== design/twal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twal_pkg
// Shared types and constants for the timed window average log.
// ----------------------------------------------------------------------------
package twal_pkg;

  localparam int DEF_LOG_DEPTH = 1024;

  localparam int WINDOW_W  = 17;
  localparam int TEMP_W    = 16;
  localparam int TIME_W    = 32;
  localparam int OUT_CNT_W = 11;
  localparam int CNT_SAT   = 2047;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 17'd3600;

  localparam logic MODE_LOG   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } twal_state_t;

endpackage
`default_nettype wire

// ===== design/timed_window_average_log.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_window_average_log
// Circular log of timestamped temperature samples with windowed average query.
// Log request: written to the log RAM, no result; next request the cycle after.
// Query request: the log RAM is scanned one entry per cycle over all stored
//   entries, then the in-window sum is divided by the count in the serial divider.
//   When no entry is in the window, the divider is skipped.
//   Next request the cycle after the result is loaded.
// Reset: control, write pointer and fill count cleared; RAM is not cleared,
//   the fill count marks which entries hold data, so no clearing pass.
// ----------------------------------------------------------------------------
module timed_window_average_log
  import twal_pkg::*;
#(
  parameter int LOG_DEPTH = DEF_LOG_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_mode,
  input  wire logic [TEMP_W-1:0]   in_temperature,
  input  wire logic [TIME_W-1:0]   in_time_now,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_has_data,
  output logic [TEMP_W-1:0]        out_average,
  output logic [OUT_CNT_W-1:0]     out_sample_count,
  input  wire logic                cfg_wr_en,
  input  wire logic [WINDOW_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam int SW = TEMP_W + CW;
  localparam int MW = SW - 1;
  localparam int XW = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;
  localparam int RW = TIME_W + TEMP_W;

  twal_state_t state_r, state_nxt;

  logic [WINDOW_W-1:0] window_r;
  logic [AW-1:0]       wp_r;
  logic [CW-1:0]       fill_r;
  logic [CW-1:0]       idx_r;
  logic                rd_vld_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   start_r;
  logic signed [SW-1:0] sum_r;
  logic [CW-1:0]       cnt_r;
  logic                out_valid_r;
  logic                out_has_r;
  logic [TEMP_W-1:0]   out_avg_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;

  logic              in_acc;
  logic              log_acc;
  logic              qry_acc;
  logic              issue;
  logic              scan_end;
  logic              div_start;
  logic              div_done;
  logic              load_out;
  logic [RW-1:0]     rd_data;
  logic [TIME_W-1:0] rd_stamp;
  logic [TEMP_W-1:0] rd_temp;
  logic              in_win;
  logic [TIME_W-1:0] win_ext;
  logic [TIME_W-1:0] q_start;
  logic [SW-1:0]     sum_abs;
  logic [MW-1:0]     div_quo;
  logic [TEMP_W-1:0] q16;
  logic [TEMP_W-1:0] avg_val;
  logic [XW-1:0]     cnt_x;
  logic [OUT_CNT_W-1:0] cnt_sat;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign log_acc  = in_acc && (in_mode == MODE_LOG);
  assign qry_acc  = in_acc && (in_mode == MODE_QUERY);

  assign win_ext = TIME_W'(window_r);
  assign q_start = (in_time_now >= win_ext) ? (in_time_now - win_ext) : '0;

  assign issue    = (state_r == ST_SCAN) && (idx_r != fill_r);
  assign scan_end = (state_r == ST_SCAN) && !issue && !rd_vld_r;

  twal_ram #(
    .WIDTH (RW),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk     (clk),
    .wr_en   (log_acc),
    .wr_addr (wp_r),
    .wr_data ({in_time_now, in_temperature}),
    .rd_en   (issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign rd_stamp = rd_data[RW-1:TEMP_W];
  assign rd_temp  = rd_data[TEMP_W-1:0];
  assign in_win   = rd_vld_r && (rd_stamp >= start_r) && (rd_stamp <= now_r);

  assign sum_abs = sum_r[SW-1] ? (SW'(0) - sum_r) : sum_r;

  twal_div #(
    .MW (MW),
    .DW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_abs[MW-1:0]),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign q16     = div_quo[TEMP_W-1:0];
  assign avg_val = (cnt_r == '0) ? '0 : (sum_r[SW-1] ? (TEMP_W'(0) - q16) : q16);
  assign cnt_x   = XW'(cnt_r);
  assign cnt_sat = (cnt_x > XW'(CNT_SAT)) ? OUT_CNT_W'(CNT_SAT) : cnt_x[OUT_CNT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (qry_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      if (log_acc) begin
        wp_r <= (wp_r == AW'(LOG_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        if (fill_r != CW'(LOG_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qry_acc) begin
      now_r   <= in_time_now;
      start_r <= q_start;
      idx_r   <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (in_win) begin
        sum_r <= sum_r + SW'(signed'(rd_temp));
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (load_out) begin
      out_has_r <= (cnt_r != '0);
      out_avg_r <= avg_val;
      out_cnt_r <= cnt_sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_has_data     = out_has_r;
  assign out_average      = out_avg_r;
  assign out_sample_count = out_cnt_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(LOG_DEPTH))
    else $error("fill count beyond log depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (cnt_r != '0))
    else $error("divider started with zero count");

  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_data) |-> (out_average == '0 && out_sample_count == '0))
    else $error("empty window result not zero");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (log_acc && fill_r != CW'(LOG_DEPTH)) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("fill count did not advance on log request");

endmodule
`default_nettype wire

// ===== design/twal_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twal_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module twal_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/twal_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twal_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twal_div #(
  parameter int MW = 26,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [MW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic      [MW-1:0] quotient
);

  localparam int CNTW = $clog2(MW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   rem_r;
  logic [MW-1:0]   quo_r;
  logic [DW-1:0]   dsr_r;
  logic [DW:0]     rem_sh;
  logic [DW:0]     diff;
  logic            q_bit;

  always_comb begin
    rem_sh = {rem_r, quo_r[MW-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    q_bit  = (rem_sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(MW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= q_bit ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_r <= {quo_r[MW-2:0], q_bit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire
